>>> hw/rtl/kli_pkg.sv
// shared constants, codes and controller/datapath interface types for the keyframe interpolator
package kli_pkg;

  // table geometry
  localparam int MAX_KF     = 16;
  localparam int IDX_W      = $clog2(MAX_KF);
  localparam int CNT_W      = $clog2(MAX_KF + 1);

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // arithmetic lanes: scale, shift_x, shift_y
  localparam int NUM_LANES  = 3;

  // request kinds carried on in_tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // which result the output register is loaded with
  typedef enum logic [1:0] {
    RES_INS,
    RES_FULL,
    RES_FEW,
    RES_QRY
  } res_kind_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX,
    RD_SEGA,
    RD_SEGB
  } rd_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_QRY_RD,
    S_QRY_CHK,
    S_FETCH_A,
    S_FETCH_B,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_OUT_INS,
    S_OUT_FULL,
    S_OUT_FEW,
    S_OUT_QRY
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      cap_in;
    logic      ins_init;
    logic      ins_shift;
    logic      ins_write;
    logic      scan_init;
    logic      scan_chk;
    logic      lat_a;
    logic      lat_b;
    logic      mul;
    logic      div_step;
    logic      out_load;
    res_kind_t kind;
    rd_sel_t   rd_sel;
  } kli_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic lt2;
    logic pos_zero;
    logic shift_gt;
    logic scan_done;
    logic den_zero;
    logic div_last;
  } kli_stat_t;

endpackage

>>> hw/rtl/kli_ctrl.sv
// controller state machine: sequences insert, segment search, divide and result hand-off
module kli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  kli_pkg::kli_stat_t stat,
  output kli_pkg::kli_cmd_t  cmd
);

  kli_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // output register may be reloaded once it is empty or being drained
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == kli_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kli_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.kind   = kli_pkg::RES_INS;
    cmd.rd_sel = kli_pkg::RD_IDX;
    case (state_r)
      kli_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = kli_pkg::S_DISPATCH;
        end
      end
      kli_pkg::S_DISPATCH: begin
        if (!stat.is_query) begin
          if (stat.full) begin
            state_nxt = kli_pkg::S_OUT_FULL;
          end else begin
            cmd.ins_init = 1'b1;
            state_nxt    = kli_pkg::S_INS_RD;
          end
        end else if (stat.lt2) begin
          state_nxt = kli_pkg::S_OUT_FEW;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = kli_pkg::S_QRY_RD;
        end
      end
      kli_pkg::S_INS_RD: begin
        if (stat.pos_zero) begin
          cmd.ins_write = 1'b1;
          state_nxt     = kli_pkg::S_OUT_INS;
        end else begin
          cmd.rd_sel = kli_pkg::RD_POS;
          state_nxt  = kli_pkg::S_INS_CMP;
        end
      end
      kli_pkg::S_INS_CMP: begin
        if (stat.shift_gt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = kli_pkg::S_INS_RD;
        end else begin
          cmd.ins_write = 1'b1;
          state_nxt     = kli_pkg::S_OUT_INS;
        end
      end
      kli_pkg::S_QRY_RD: begin
        cmd.rd_sel = kli_pkg::RD_IDX;
        state_nxt  = kli_pkg::S_QRY_CHK;
      end
      kli_pkg::S_QRY_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = stat.scan_done ? kli_pkg::S_FETCH_A : kli_pkg::S_QRY_RD;
      end
      kli_pkg::S_FETCH_A: begin
        cmd.rd_sel = kli_pkg::RD_SEGA;
        state_nxt  = kli_pkg::S_FETCH_B;
      end
      kli_pkg::S_FETCH_B: begin
        cmd.rd_sel = kli_pkg::RD_SEGB;
        cmd.lat_a  = 1'b1;
        state_nxt  = kli_pkg::S_LOAD;
      end
      kli_pkg::S_LOAD: begin
        cmd.lat_b = 1'b1;
        state_nxt = kli_pkg::S_MUL;
      end
      kli_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.den_zero ? kli_pkg::S_OUT_QRY : kli_pkg::S_DIV;
      end
      kli_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = kli_pkg::S_OUT_QRY;
        end
      end
      kli_pkg::S_OUT_INS: begin
        cmd.kind = kli_pkg::RES_INS;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kli_pkg::S_IDLE;
        end
      end
      kli_pkg::S_OUT_FULL: begin
        cmd.kind = kli_pkg::RES_FULL;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kli_pkg::S_IDLE;
        end
      end
      kli_pkg::S_OUT_FEW: begin
        cmd.kind = kli_pkg::RES_FEW;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kli_pkg::S_IDLE;
        end
      end
      kli_pkg::S_OUT_QRY: begin
        cmd.kind = kli_pkg::RES_QRY;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = kli_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kli_pkg::S_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the result is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

>>> hw/rtl/kli_dp.sv
// datapath: keyframe table memory, search registers, multipliers, divider lanes, output register
module kli_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  kli_pkg::kli_cmd_t  cmd,
  output kli_pkg::kli_stat_t stat,
  input  logic               in_tuser,
  input  logic [63:0]        in_tdata,
  output logic [1:0]         out_tuser,
  output logic [63:0]        out_tdata
);

  typedef struct packed {
    logic signed [15:0] sy;
    logic signed [15:0] sx;
    logic        [15:0] scale;
    logic        [15:0] depth;
  } kf_t;

  // request and table state
  logic                      req_r;
  kf_t                       new_r;
  logic [kli_pkg::CNT_W-1:0] count_r;
  logic [kli_pkg::CNT_W-1:0] pos_r;
  logic [kli_pkg::IDX_W-1:0] idx_r;
  logic [kli_pkg::IDX_W-1:0] seg_r;
  logic [15:0]               prev_r;
  logic                      below_r;
  kf_t                       mem [kli_pkg::MAX_KF];
  kf_t                       rdata_r;
  kf_t                       a_r;
  kf_t                       b_r;
  logic [kli_pkg::IDX_W-1:0] raddr;

  // divider lanes
  logic [31:0]                   num_r [kli_pkg::NUM_LANES];
  logic [15:0]                   rem_r [kli_pkg::NUM_LANES];
  logic                          neg_r [kli_pkg::NUM_LANES];
  logic [kli_pkg::DIV_CNT_W-1:0] div_cnt_r;

  // output register
  logic [1:0]  out_tuser_r;
  logic [63:0] out_tdata_r;

  // derived values
  logic [kli_pkg::CNT_W-1:0] pos_m1;
  logic [kli_pkg::CNT_W-1:0] cnt_m1;
  logic [kli_pkg::CNT_W-1:0] cnt_m2;
  logic                      scan_hit;
  logic                      scan_last;
  logic signed [16:0]        dd;
  logic [15:0]               den;
  logic signed [16:0]        v0 [kli_pkg::NUM_LANES];
  logic signed [16:0]        v1 [kli_pkg::NUM_LANES];
  logic signed [16:0]        dv [kli_pkg::NUM_LANES];
  logic signed [33:0]        prod [kli_pkg::NUM_LANES];
  logic signed [33:0]        res [kli_pkg::NUM_LANES];
  logic [16:0]               sat_res [kli_pkg::NUM_LANES];
  logic                      any_sat;

  // clamp one lane to its 16-bit range, top bit flags a clamp
  function automatic logic [16:0] sat16(input logic signed [33:0] v, input logic uns);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic [16:0]        r;
    lo = uns ? 34'sd0 : -34'sd32768;
    hi = uns ? 34'sd65535 : 34'sd32767;
    if (v < lo) begin
      r = {1'b1, lo[15:0]};
    end else if (v > hi) begin
      r = {1'b1, hi[15:0]};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  assign pos_m1 = pos_r - kli_pkg::CNT_W'(1);
  assign cnt_m1 = count_r - kli_pkg::CNT_W'(1);
  assign cnt_m2 = count_r - kli_pkg::CNT_W'(2);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      kli_pkg::RD_POS:  raddr = pos_m1[kli_pkg::IDX_W-1:0];
      kli_pkg::RD_IDX:  raddr = idx_r;
      kli_pkg::RD_SEGA: raddr = seg_r;
      kli_pkg::RD_SEGB: raddr = seg_r + kli_pkg::IDX_W'(1);
      default:          raddr = idx_r;
    endcase
  end

  // keyframe table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      mem[pos_r[kli_pkg::IDX_W-1:0]] <= rdata_r;
    end else if (cmd.ins_write) begin
      mem[pos_r[kli_pkg::IDX_W-1:0]] <= new_r;
    end
    rdata_r <= mem[raddr];
  end

  // keyframe count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins_write) begin
      count_r <= count_r + kli_pkg::CNT_W'(1);
    end
  end

  // segment search compare on the entry just read
  assign scan_hit  = (idx_r != '0) && (prev_r <= new_r.depth) && (new_r.depth <= rdata_r.depth);
  assign scan_last = ({1'b0, idx_r} == cnt_m1);

  // request capture, insert position and search registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_r <= in_tuser;
      new_r <= kf_t'(in_tdata);
    end
    if (cmd.ins_init) begin
      pos_r <= count_r;
    end else if (cmd.ins_shift) begin
      pos_r <= pos_m1;
    end
    if (cmd.scan_init) begin
      idx_r <= '0;
    end else if (cmd.scan_chk) begin
      idx_r  <= idx_r + kli_pkg::IDX_W'(1);
      prev_r <= rdata_r.depth;
      if (idx_r == '0) begin
        below_r <= new_r.depth < rdata_r.depth;
      end
      if (scan_hit) begin
        seg_r <= idx_r - kli_pkg::IDX_W'(1);
      end else if (scan_last) begin
        seg_r <= below_r ? '0 : cnt_m2[kli_pkg::IDX_W-1:0];
      end
    end
    if (cmd.lat_a) begin
      a_r <= rdata_r;
    end
    if (cmd.lat_b) begin
      b_r <= rdata_r;
    end
  end

  // segment endpoints per lane
  assign dd  = $signed({1'b0, new_r.depth}) - $signed({1'b0, a_r.depth});
  assign den = b_r.depth - a_r.depth;

  always_comb begin
    v0[0] = $signed({1'b0, a_r.scale});
    v1[0] = $signed({1'b0, b_r.scale});
    v0[1] = {a_r.sx[15], a_r.sx};
    v1[1] = {b_r.sx[15], b_r.sx};
    v0[2] = {a_r.sy[15], a_r.sy};
    v1[2] = {b_r.sy[15], b_r.sy};
  end

  // per-lane product, divide and result
  always_comb begin
    logic signed [33:0] q;
    logic signed [33:0] sq;
    any_sat = 1'b0;
    for (int l = 0; l < kli_pkg::NUM_LANES; l++) begin
      dv[l]   = v1[l] - v0[l];
      prod[l] = dd * dv[l];
      q       = $signed({2'b00, num_r[l]});
      sq      = neg_r[l] ? -q : q;
      res[l]  = (den == '0) ? 34'(v0[l]) : 34'(v0[l]) + sq;
      sat_res[l] = sat16(res[l], (l == 0));
      any_sat = any_sat | sat_res[l][16];
    end
  end

  // divider lanes: load magnitude, then one restoring step per cycle
  always_ff @(posedge clk) begin
    logic [16:0] rem_sh;
    logic        ge;
    if (cmd.mul) begin
      div_cnt_r <= '0;
      for (int l = 0; l < kli_pkg::NUM_LANES; l++) begin
        neg_r[l] <= prod[l] < 0;
        num_r[l] <= prod[l] < 0 ? 32'(-prod[l]) : prod[l][31:0];
        rem_r[l] <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + kli_pkg::DIV_CNT_W'(1);
      for (int l = 0; l < kli_pkg::NUM_LANES; l++) begin
        rem_sh   = {rem_r[l], num_r[l][31]};
        ge       = rem_sh >= {1'b0, den};
        rem_r[l] <= ge ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
        num_r[l] <= {num_r[l][30:0], ge};
      end
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.kind)
        kli_pkg::RES_INS: begin
          out_tuser_r <= kli_pkg::ST_OK;
          out_tdata_r <= {48'd0, new_r.depth};
        end
        kli_pkg::RES_FULL: begin
          out_tuser_r <= kli_pkg::ST_FULL;
          out_tdata_r <= {48'd0, new_r.depth};
        end
        kli_pkg::RES_FEW: begin
          out_tuser_r <= kli_pkg::ST_FEW;
          out_tdata_r <= {48'd0, new_r.depth};
        end
        kli_pkg::RES_QRY: begin
          out_tuser_r <= any_sat ? kli_pkg::ST_SAT : kli_pkg::ST_OK;
          out_tdata_r <= {sat_res[2][15:0], sat_res[1][15:0], sat_res[0][15:0], new_r.depth};
        end
        default: begin
          out_tuser_r <= kli_pkg::ST_OK;
          out_tdata_r <= {48'd0, new_r.depth};
        end
      endcase
    end
  end

  assign out_tuser = out_tuser_r;
  assign out_tdata = out_tdata_r;

  // status to controller
  always_comb begin
    stat.is_query  = (req_r == kli_pkg::REQ_QUERY);
    stat.full      = (count_r == kli_pkg::CNT_W'(kli_pkg::MAX_KF));
    stat.lt2       = (count_r < kli_pkg::CNT_W'(2));
    stat.pos_zero  = (pos_r == '0);
    stat.shift_gt  = (rdata_r.depth > new_r.depth);
    stat.scan_done = scan_hit || scan_last;
    stat.den_zero  = (den == '0);
    stat.div_last  = (div_cnt_r == kli_pkg::DIV_CNT_W'(kli_pkg::DIV_STEPS - 1));
  end

endmodule

>>> hw/rtl/keyframe_linear_interpolator.sv
// top level of the keyframe linear interpolator: controller, datapath and checks
//
// Input channel in_*: one request per accepted item. in_tuser is the request kind
// (0 insert keyframe, 1 query at depth). An insert places the keyframe in depth
// order after equal depths; a query interpolates scale and both offsets on the
// first bracketing segment, or on the nearest end segment outside the table.
// Output channel out_*: exactly one result per request; out_tuser is the status
// (0 ok, 1 table full, 2 fewer than two keyframes, 3 saturated).
// Timing: in_tready is high only while the engine is idle. An insert's time
// grows with the keyframes moved up (the table has a single read port). A
// query's time grows with the keyframes scanned and is set by the serial
// table scan and the 32-step restoring divider run on the three lanes
// together; a zero-width segment skips the divider.
// A finished result sits in the output register; while the receiver stalls the
// next request is still accepted and worked on, and waits at its hand-off
// until the register frees. Reset empties the table and the output register
// and returns the engine to idle.
module keyframe_linear_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // req_type
  input  logic [63:0] in_tdata,   // depth, scale, shift_x, shift_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status
  output logic [63:0] out_tdata   // out_depth, out_scale, out_shift_x, out_shift_y
);

  kli_pkg::kli_cmd_t  cmd;
  kli_pkg::kli_stat_t stat;

  // sequencer
  kli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // table and arithmetic
  kli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

`ifndef SYNTH
  // a new request closes the input until its result is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // an insert never writes into a full table
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> !stat.full)
    else $error("keyframe written into full table");

  // error results carry zero values
  a_error_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == kli_pkg::ST_FULL || out_tuser == kli_pkg::ST_FEW))
      |-> (out_tdata[63:16] == 48'd0))
    else $error("error result with nonzero values");
`endif

endmodule

>>> bench/keyframe_linear_interpolator_tb.sv
// self-checking bench for the keyframe interpolator: directed table, random requests, scoreboard
module keyframe_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kli_pkg::*;

  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 1500;
  localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
  localparam int QUIET_TAIL  = 200;     // last requests run with no idling
  localparam int HOLD_AT     = 60;      // results seen before the long receiver hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 100;
  localparam int CYCLE_LIMIT = 600000;

  // one keyframe as the table keeps it
  typedef struct packed {
    logic [15:0]        depth;
    logic [15:0]        scale;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } keyframe_t;

  // one result: status, depth echo and the three interpolated values
  typedef struct packed {
    status_t            st;
    logic [15:0]        depth;
    logic [15:0]        scale;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } calib_point_t;

  // one stimulus row; typed rows carry their own expected values
  typedef struct packed {
    logic               kind;
    logic [15:0]        depth;
    logic [15:0]        scale;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               typed;
    status_t            st;
    logic [15:0]        e_scale;
    logic signed [15:0] e_sx;
    logic signed [15:0] e_sy;
  } req_row_t;

  // directed requests: errors, extremes, ordering, extrapolation, zero-width, full table
  localparam req_row_t DIRECTED_REQS [N_DIRECTED] = '{
    // empty table, then a single keyframe: too few to interpolate
    '{REQ_QUERY,  16'd0,     16'hFFFF, 16'h7FFF, 16'h8000, 1'b1, ST_FEW,  16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd1000,  16'h1000, 16'h0000, 16'h0000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd1000,  16'h0000, 16'h0000, 16'h0000, 1'b1, ST_FEW,  16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd3000,  16'h5000, 16'h00A0, 16'h8000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    // midpoint, extrapolation below (scale clips low) and above (scale high, sy low)
    '{REQ_QUERY,  16'd2000,  16'h0000, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd0,     16'h0000, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd65535, 16'h0000, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    // equal depth goes after the existing one; last segment becomes zero width
    '{REQ_INSERT, 16'd3000,  16'h0000, 16'h7FFF, 16'h8000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd3000,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd65535, 16'h0000, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    // extreme keyframes at both ends of the depth range
    '{REQ_INSERT, 16'd0,     16'hFFFF, 16'h8000, 16'h7FFF, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd65535, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_QUERY,  16'd40000, 16'h0000, 16'h0000, 16'h0000, 1'b0, ST_OK,   16'h0, 16'h0, 16'h0},
    // fill the table with varied segments
    '{REQ_INSERT, 16'd500,   16'h0800, 16'hFFFF, 16'h0001, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd1000,  16'h2000, 16'h0100, 16'hFF00, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd2000,  16'h0001, 16'h8000, 16'h7FFF, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd8000,  16'h4000, 16'h0000, 16'h0000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd8000,  16'hC000, 16'h7FFF, 16'h8000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd20000, 16'h0000, 16'h8000, 16'h8000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd20001, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd30000, 16'h1234, 16'h0ABC, 16'hF543, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd65535, 16'h0000, 16'h0000, 16'h0000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd100,   16'h3333, 16'h0FFF, 16'hF001, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    '{REQ_INSERT, 16'd45000, 16'h8000, 16'hC000, 16'h4000, 1'b1, ST_OK,   16'h0, 16'h0, 16'h0},
    // table now holds sixteen keyframes
    '{REQ_INSERT, 16'd12345, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b1, ST_FULL, 16'h0, 16'h0, 16'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;
  logic [63:0] out_tdata;

  keyframe_t    kf_store [MAX_KF];
  int           kf_used = 0;
  calib_point_t awaited_points [$];
  calib_point_t head_point;
  int           mismatches = 0;
  int           results_seen = 0;
  int           hold_left = 0;
  int           stall_left = 0;
  bit           hold_done = 1'b0;
  int           cycles = 0;

  keyframe_linear_interpolator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // v0 plus the scaled step; integer division truncates toward zero
  function automatic longint lerp(longint v0, longint v1, longint dd, longint den);
    return v0 + (dd * (v1 - v0)) / den;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // applies one request to the keyframe table and returns the result it should give
  function automatic calib_point_t run_request(logic kind, logic [15:0] d, logic [15:0] sc,
                                               logic signed [15:0] x, logic signed [15:0] y);
    calib_point_t pt;
    keyframe_t    a;
    keyframe_t    b;
    int           pos;
    int           seg;
    int           k;
    bit           found;
    longint       dd;
    longint       den;
    longint       rs;
    longint       rx;
    longint       ry;
    longint       cs;
    longint       cx;
    longint       cy;
    pt = '{ST_OK, d, 16'h0, 16'h0, 16'h0};
    found = 1'b0;
    if (kind == REQ_INSERT) begin
      if (kf_used >= MAX_KF) begin
        pt.st = ST_FULL;
      end else begin
        // shift larger depths up, new keyframe lands after equal depths
        pos = kf_used;
        while (pos > 0 && kf_store[pos-1].depth > d) begin
          kf_store[pos] = kf_store[pos-1];
          pos--;
        end
        kf_store[pos] = '{d, sc, x, y};
        kf_used++;
      end
    end else if (kf_used < 2) begin
      pt.st = ST_FEW;
    end else begin
      // first bracketing segment, else the nearest end segment
      seg = (d < kf_store[0].depth) ? 0 : kf_used - 2;
      for (k = 0; k <= kf_used - 2; k++) begin
        if (!found && d >= kf_store[k].depth && d <= kf_store[k+1].depth) begin
          seg = k;
          found = 1'b1;
        end
      end
      a = kf_store[seg];
      b = kf_store[seg+1];
      if (a.depth == b.depth) begin
        rs = longint'(a.scale);
        rx = longint'(a.sx);
        ry = longint'(a.sy);
      end else begin
        dd = longint'(d) - longint'(a.depth);
        den = longint'(b.depth) - longint'(a.depth);
        rs = lerp(longint'(a.scale), longint'(b.scale), dd, den);
        rx = lerp(longint'(a.sx), longint'(b.sx), dd, den);
        ry = lerp(longint'(a.sy), longint'(b.sy), dd, den);
      end
      cs = clip(rs, 0, 65535);
      cx = clip(rx, -32768, 32767);
      cy = clip(ry, -32768, 32767);
      if (cs != rs || cx != rx || cy != ry) pt.st = ST_SAT;
      pt.scale = cs[15:0];
      pt.sx = cx[15:0];
      pt.sy = cy[15:0];
    end
    return pt;
  endfunction

  function automatic void compare_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // offers one request until accepted, then records what it should produce
  task automatic offer_request(input req_row_t r);
    calib_point_t pt;
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {r.sy, r.sx, r.scale, r.depth};
    do @(posedge clk); while (!in_tready);
    pt = run_request(r.kind, r.depth, r.scale, r.sx, r.sy);
    if (r.typed) pt = '{r.st, r.depth, r.e_scale, r.e_sx, r.e_sy};
    awaited_points = {awaited_points, pt};
  endtask

  // random sender gap after a request, none in the quiet tail
  task automatic maybe_pause(input int idx);
    if (idx < N_TOTAL - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // sender: reset, directed table, random requests, drain
  initial begin
    int       i;
    int       near;
    req_row_t row;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_INSERT;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      offer_request(DIRECTED_REQS[i]);
      maybe_pause(i);
    end

    // mostly queries, some near keyframe depths; inserts now hit the full table
    for (i = 0; i < N_RANDOM; i++) begin
      row = '0;
      row.kind  = ($urandom_range(0, 99) < 15) ? REQ_INSERT : REQ_QUERY;
      row.depth = 16'($urandom_range(0, 65535));
      if (kf_used > 0 && $urandom_range(0, 9) < 4) begin
        near = int'(kf_store[$urandom_range(0, kf_used - 1)].depth)
               + int'($urandom_range(0, 6)) - 3;
        row.depth = (near < 0) ? 16'd0 : ((near > 65535) ? 16'hFFFF : near[15:0]);
      end
      row.scale = 16'($urandom);
      row.sx    = 16'($urandom);
      row.sy    = 16'($urandom);
      offer_request(row);
      maybe_pause(N_DIRECTED + i);
    end
    in_tvalid <= 1'b0;

    while (awaited_points.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: check each accepted result, then decide next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (awaited_points.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with none expected, status %0d data %h",
                 $time, out_tuser, out_tdata);
      end else begin
        head_point = awaited_points.pop_front();
        compare_field("status", 16'(head_point.st), 16'(out_tuser));
        compare_field("depth", head_point.depth, out_tdata[15:0]);
        compare_field("scale", head_point.scale, out_tdata[31:16]);
        compare_field("shift_x", head_point.sx, out_tdata[47:32]);
        compare_field("shift_y", head_point.sy, out_tdata[63:48]);
      end
    end

    // one long hold so the block fills and stalls its input, then short bursts
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (results_seen < N_TOTAL - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still awaited", $time, awaited_points.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
